// File: hdl/cfpc_pkg.sv
`timescale 1ns / 1ps
package cfpc_pkg;

    localparam int TIME_BITS     = 63;
    localparam int INTERVAL_BITS = 24;
    localparam int SPACING_BITS  = 8;
    localparam int SIZE_BITS     = 14;
    localparam int ACTION_BITS   = 3;
    localparam int REPORT_BITS   = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    localparam int COUNT_BITS_DEFAULT = 32;

    localparam logic [INTERVAL_BITS-1:0] FRAME_INTERVAL_RESET   = 24'd166666;
    localparam logic [SPACING_BITS-1:0]  KEYFRAME_SPACING_RESET = 8'd30;
    localparam logic [SIZE_BITS-1:0]     EXPECTED_WIDTH_RESET   = 14'd1920;
    localparam logic [SIZE_BITS-1:0]     EXPECTED_HEIGHT_RESET  = 14'd1080;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_INTERVAL   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_KEYFRAME_SPACING = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXPECTED_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXPECTED_HEIGHT  = 2'd3;

    localparam logic [ACTION_BITS-1:0] ACT_SKIPPED   = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_WRITTEN   = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_DROPPED   = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_REJECTED  = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_SIZE_STOP = 3'd4;
    localparam logic [ACTION_BITS-1:0] ACT_IGNORED   = 3'd5;
    localparam logic [ACTION_BITS-1:0] ACT_ROTATED   = 3'd6;

    localparam logic MODE_FRAME  = 1'b0;
    localparam logic MODE_ROTATE = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [TIME_BITS-1:0]  capture_time;
        logic [SIZE_BITS-1:0]  frame_width;
        logic [SIZE_BITS-1:0]  frame_height;
        logic                  buffer_free;
        logic                  encoder_accepts;
    } item_t;

    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        logic [TIME_BITS-1:0]   sample_time;
        logic                   force_keyframe;
        logic [REPORT_BITS-1:0] written_count;
        logic [REPORT_BITS-1:0] dropped_count;
        logic [REPORT_BITS-1:0] rejected_count;
    } result_t;

    typedef struct packed {
        logic [INTERVAL_BITS-1:0] frame_interval;
        logic [SPACING_BITS-1:0]  keyframe_spacing;
        logic [SIZE_BITS-1:0]     expected_width;
        logic [SIZE_BITS-1:0]     expected_height;
    } cfg_t;

endpackage

// File: hdl/cfpc_chan_if.sv
`timescale 1ns / 1ps
interface cfpc_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/cfpc_cfg_regs.sv
`timescale 1ns / 1ps
module cfpc_cfg_regs
    import cfpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_INTERVAL:   cfg_next.frame_interval = cfg_data[INTERVAL_BITS-1:0];
                REG_KEYFRAME_SPACING: cfg_next.keyframe_spacing = cfg_data[SPACING_BITS-1:0];
                REG_EXPECTED_WIDTH:   cfg_next.expected_width = cfg_data[SIZE_BITS-1:0];
                REG_EXPECTED_HEIGHT:  cfg_next.expected_height = cfg_data[SIZE_BITS-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_interval   <= FRAME_INTERVAL_RESET;
            cfg_reg.keyframe_spacing <= KEYFRAME_SPACING_RESET;
            cfg_reg.expected_width   <= EXPECTED_WIDTH_RESET;
            cfg_reg.expected_height  <= EXPECTED_HEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/cfpc_in_stage.sv
`timescale 1ns / 1ps
module cfpc_in_stage
    import cfpc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cfpc_chan_if.sink frames,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign frames.ready = !valid_reg || advance;
    assign take         = frames.valid && frames.ready;
    assign valid_next   = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= frames.payload;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hdl/cfpc_pacer.sv
`timescale 1ns / 1ps
module cfpc_pacer
    import cfpc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    advance,
    input  item_t   item,
    output result_t result
);

    logic                    started_reg, started_next;
    logic                    stopped_reg, stopped_next;
    logic [TIME_BITS-1:0]    due_reg, due_next;
    logic [TIME_BITS-1:0]    origin_reg, origin_next;
    logic [TIME_BITS-1:0]    newest_reg, newest_next;
    logic [SPACING_BITS-1:0] phase_reg, phase_next;
    logic [COUNT_BITS-1:0]   written_reg, written_next;
    logic [COUNT_BITS-1:0]   dropped_reg, dropped_next;
    logic [COUNT_BITS-1:0]   rejected_reg, rejected_next;

    logic [TIME_BITS-1:0]    t;
    logic [TIME_BITS-1:0]    interval;
    logic [TIME_BITS-1:0]    due_eff;
    logic [TIME_BITS-1:0]    origin_eff;
    logic [TIME_BITS:0]      ahead_sum;
    logic [TIME_BITS-1:0]    ahead;
    logic [TIME_BITS-1:0]    floor_t;
    logic [TIME_BITS-1:0]    sample;
    logic [SPACING_BITS:0]   phase_inc;
    logic [SPACING_BITS-1:0] spacing_eff;
    logic                    size_ok;

    logic [ACTION_BITS-1:0]  action;
    logic [TIME_BITS-1:0]    sample_time;
    logic                    force_keyframe;

    assign t           = item.capture_time;
    assign interval    = TIME_BITS'(cfg.frame_interval);
    assign due_eff     = started_reg ? due_reg : t;
    assign origin_eff  = started_reg ? origin_reg : t;
    assign ahead_sum   = {1'b0, due_eff} + {1'b0, interval};
    assign ahead       = ahead_sum[TIME_BITS] ? TIME_MAX : ahead_sum[TIME_BITS-1:0];
    assign floor_t     = (t >= interval) ? (t - interval) : '0;
    assign sample      = (t >= origin_eff) ? (t - origin_eff) : '0;
    assign phase_inc   = {1'b0, phase_reg} + {{SPACING_BITS{1'b0}}, 1'b1};
    assign spacing_eff = (cfg.keyframe_spacing == '0) ? SPACING_BITS'(1)
                                                      : cfg.keyframe_spacing;
    assign size_ok     = (item.frame_width == cfg.expected_width)
                      && (item.frame_height == cfg.expected_height);

    always_comb
    begin
        started_next   = started_reg;
        stopped_next   = stopped_reg;
        due_next       = due_reg;
        origin_next    = origin_reg;
        newest_next    = newest_reg;
        phase_next     = phase_reg;
        written_next   = written_reg;
        dropped_next   = dropped_reg;
        rejected_next  = rejected_reg;
        action         = ACT_IGNORED;
        sample_time    = '0;
        force_keyframe = 1'b0;

        if (stopped_reg)
        begin
            action = ACT_IGNORED;
        end
        else if (item.mode == MODE_ROTATE)
        begin
            origin_next = newest_reg;
            action      = ACT_ROTATED;
        end
        else if (!size_ok)
        begin
            stopped_next = 1'b1;
            action       = ACT_SIZE_STOP;
        end
        else
        begin
            started_next = 1'b1;
            origin_next  = origin_eff;
            newest_next  = t;
            due_next     = due_eff;
            if (t < due_eff)
            begin
                action = ACT_SKIPPED;
            end
            else
            begin
                due_next = (ahead > floor_t) ? ahead : floor_t;
                if (!item.buffer_free)
                begin
                    if (dropped_reg != '1)
                    begin
                        dropped_next = dropped_reg + COUNT_BITS'(1);
                    end
                    action = ACT_DROPPED;
                end
                else
                begin
                    sample_time    = sample;
                    force_keyframe = (phase_reg == '0);
                    if (item.encoder_accepts)
                    begin
                        if (written_reg != '1)
                        begin
                            written_next = written_reg + COUNT_BITS'(1);
                        end
                        phase_next = (phase_inc >= {1'b0, spacing_eff})
                                   ? '0 : phase_inc[SPACING_BITS-1:0];
                        action     = ACT_WRITTEN;
                    end
                    else
                    begin
                        if (rejected_reg != '1)
                        begin
                            rejected_next = rejected_reg + COUNT_BITS'(1);
                        end
                        action = ACT_REJECTED;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            stopped_reg  <= 1'b0;
            due_reg      <= '0;
            origin_reg   <= '0;
            newest_reg   <= '0;
            phase_reg    <= '0;
            written_reg  <= '0;
            dropped_reg  <= '0;
            rejected_reg <= '0;
        end
        else if (advance)
        begin
            started_reg  <= started_next;
            stopped_reg  <= stopped_next;
            due_reg      <= due_next;
            origin_reg   <= origin_next;
            newest_reg   <= newest_next;
            phase_reg    <= phase_next;
            written_reg  <= written_next;
            dropped_reg  <= dropped_next;
            rejected_reg <= rejected_next;
        end
    end

    assign result.action         = action;
    assign result.sample_time    = sample_time;
    assign result.force_keyframe = force_keyframe;
    assign result.written_count  = REPORT_BITS'(written_next);
    assign result.dropped_count  = REPORT_BITS'(dropped_next);
    assign result.rejected_count = REPORT_BITS'(rejected_next);

endmodule

// File: hdl/cfpc_out_stage.sv
`timescale 1ns / 1ps
module cfpc_out_stage
    import cfpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    can_load,
    cfpc_chan_if.source results
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || results.ready;
    assign valid_next = load || (valid_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign results.valid   = valid_reg;
    assign results.payload = result_reg;

endmodule

// File: hdl/capture_frame_pacer_core.sv
`timescale 1ns / 1ps
// capture frame pacer: one request in per cycle, one result out per request, in order.
// a request is registered in the input register, is judged against the pacing state
// (due time, segment origin, keyframe phase, saturating counters) and lands in the result
// register; throughput is one request per cycle while the results side keeps ready
// high; frames.ready follows results.ready within the same cycle.
// counters are COUNT_BITS wide and reported in their low 32 bits.
// configuration writes take effect on the next cycle and belong to idle periods only.
module capture_frame_pacer_core
    import cfpc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    cfpc_chan_if.sink                frames,
    cfpc_chan_if.source              results
);

    cfg_t    cfg;
    logic    item_valid;
    item_t   item;
    result_t result;
    logic    can_load;
    logic    advance;

    assign advance = item_valid && can_load;

    cfpc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cfpc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .frames     (frames),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cfpc_pacer #(
        .COUNT_BITS (COUNT_BITS)
    ) u_pacer (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    cfpc_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .results  (results)
    );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import cfpc_pkg::*;

    localparam int MAX_CYCLES = 1000000;
    localparam int MAX_PRINTS = 40;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    cfpc_chan_if #(.payload_t(item_t))   frames_if ();
    cfpc_chan_if #(.payload_t(result_t)) results_if ();

    capture_frame_pacer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frames    (frames_if),
        .results   (results_if)
    );

    // pacing state mirror
    logic [INTERVAL_BITS-1:0] interval_cfg;
    logic [SPACING_BITS-1:0]  spacing_cfg;
    logic [SIZE_BITS-1:0]     width_cfg;
    logic [SIZE_BITS-1:0]     height_cfg;
    logic                     started_q;
    logic                     stopped_q;
    logic [TIME_BITS-1:0]     due_q;
    logic [TIME_BITS-1:0]     origin_q;
    logic [TIME_BITS-1:0]     newest_q;
    logic [SPACING_BITS-1:0]  phase_q;
    logic [REPORT_BITS-1:0]   written_q;
    logic [REPORT_BITS-1:0]   dropped_q;
    logic [REPORT_BITS-1:0]   rejected_q;

    result_t outcome_q[$];
    int      mismatch_count;
    int      cycle_count;
    bit      tx_idle_on;
    bit      rx_idle_on;
    int      rx_stall_left;
    bit      jump_pending;
    logic [TIME_BITS-1:0] jump_base;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [REPORT_BITS-1:0] sat_inc(logic [REPORT_BITS-1:0] c);
        return (c == {REPORT_BITS{1'b1}}) ? c : c + REPORT_BITS'(1);
    endfunction

    function automatic result_t pace_frame(item_t it);
        result_t                  r;
        logic [TIME_BITS:0]       ahead;
        logic [TIME_BITS-1:0]     floor_t;
        logic [TIME_BITS-1:0]     t;
        logic [TIME_BITS-1:0]     iv;
        logic [SPACING_BITS:0]    next_phase;
        logic [SPACING_BITS-1:0]  spacing;
        r  = '0;
        t  = it.capture_time;
        iv = TIME_BITS'(interval_cfg);
        if (stopped_q) begin
            r.action = ACT_IGNORED;
        end
        else if (it.mode == MODE_ROTATE) begin
            origin_q = newest_q;
            r.action = ACT_ROTATED;
        end
        else if (it.frame_width != width_cfg || it.frame_height != height_cfg) begin
            stopped_q = 1'b1;
            r.action  = ACT_SIZE_STOP;
        end
        else begin
            if (!started_q) begin
                started_q = 1'b1;
                origin_q  = t;
                due_q     = t;
            end
            newest_q = t;
            if (t < due_q) begin
                r.action = ACT_SKIPPED;
            end
            else begin
                ahead = {1'b0, due_q} + {1'b0, iv};
                if (ahead > {1'b0, TIME_MAX})
                    ahead = {1'b0, TIME_MAX};
                floor_t = (t >= iv) ? t - iv : '0;
                due_q   = (ahead[TIME_BITS-1:0] > floor_t) ? ahead[TIME_BITS-1:0] : floor_t;
                if (!it.buffer_free) begin
                    dropped_q = sat_inc(dropped_q);
                    r.action  = ACT_DROPPED;
                end
                else begin
                    r.force_keyframe = (phase_q == '0);
                    r.sample_time    = (t >= origin_q) ? t - origin_q : '0;
                    if (it.encoder_accepts) begin
                        written_q  = sat_inc(written_q);
                        spacing    = (spacing_cfg == '0) ? 8'd1 : spacing_cfg;
                        next_phase = {1'b0, phase_q} + (SPACING_BITS+1)'(1);
                        phase_q    = (next_phase >= {1'b0, spacing})
                                   ? '0 : next_phase[SPACING_BITS-1:0];
                        r.action   = ACT_WRITTEN;
                    end
                    else begin
                        rejected_q = sat_inc(rejected_q);
                        r.action   = ACT_REJECTED;
                    end
                end
            end
        end
        r.written_count  = written_q;
        r.dropped_count  = dropped_q;
        r.rejected_count = rejected_q;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_BITS-1:0];
    endfunction

    // mostly on-pace frames, some early, late, behind and far jumps
    function automatic logic [TIME_BITS-1:0] pick_capture_time();
        logic [63:0] iv;
        logic [63:0] base;
        logic [63:0] t64;
        logic [63:0] span;
        int          r;
        iv   = 64'(interval_cfg);
        base = 64'(newest_q);
        if (jump_pending) begin
            jump_pending = 1'b0;
            t64 = 64'(jump_base) + 64'($urandom_range(0, 1000));
        end
        else begin
            r = $urandom_range(0, 99);
            if (r < 62) begin
                t64 = base + iv + 64'($urandom_range(0, 32'(iv / 4)));
                t64 = t64 - 64'($urandom_range(0, 32'(iv / 4)));
            end
            else if (r < 74) begin
                t64 = base + 64'($urandom_range(0, 32'(iv / 2)));
            end
            else if (r < 82) begin
                t64 = base + iv * 64'($urandom_range(2, 40))
                    + 64'($urandom_range(0, 32'(iv)));
            end
            else if (r < 92) begin
                span = 64'($urandom_range(0, 32'(iv)));
                t64  = (base > span) ? base - span : '0;
            end
            else begin
                t64 = {$urandom, $urandom};
                t64 = t64 % (64'(due_q) + 64'd1);
            end
        end
        if (t64 > 64'(TIME_MAX))
            t64 = 64'(TIME_MAX);
        return t64[TIME_BITS-1:0];
    endfunction

    function automatic item_t make_frame(logic [TIME_BITS-1:0] t, logic bf, logic ea);
        item_t it;
        it.mode            = MODE_FRAME;
        it.capture_time    = t;
        it.frame_width     = width_cfg;
        it.frame_height    = height_cfg;
        it.buffer_free     = bf;
        it.encoder_accepts = ea;
        return it;
    endfunction

    function automatic item_t random_frame();
        return make_frame(pick_capture_time(), $urandom_range(0, 99) < 88,
                          $urandom_range(0, 99) < 85);
    endfunction

    function automatic item_t random_rotation();
        item_t it;
        it.mode            = MODE_ROTATE;
        it.capture_time    = rand_time();
        it.frame_width     = SIZE_BITS'($urandom_range(0, 16383));
        it.frame_height    = SIZE_BITS'($urandom_range(0, 16383));
        it.buffer_free     = 1'($urandom_range(0, 1));
        it.encoder_accepts = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic reset_model();
        interval_cfg = FRAME_INTERVAL_RESET;
        spacing_cfg  = KEYFRAME_SPACING_RESET;
        width_cfg    = EXPECTED_WIDTH_RESET;
        height_cfg   = EXPECTED_HEIGHT_RESET;
        started_q    = 1'b0;
        stopped_q    = 1'b0;
        due_q        = '0;
        origin_q     = '0;
        newest_q     = '0;
        phase_q      = '0;
        written_q    = '0;
        dropped_q    = '0;
        rejected_q   = '0;
    endtask

    task automatic send_frame(input item_t it);
        int gap;
        if (tx_idle_on && $urandom_range(0, 99) < 25) begin
            gap = pick_gap();
            frames_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frames_if.valid   <= 1'b1;
        frames_if.payload <= it;
        @(posedge clk);
        while (!frames_if.ready)
            @(posedge clk);
        outcome_q = {outcome_q, pace_frame(it)};
    endtask

    task automatic wait_idle();
        frames_if.valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // upper data bits beyond a register's width are junk on purpose
    task automatic set_config(input logic [INTERVAL_BITS-1:0] iv,
                              input logic [SPACING_BITS-1:0] sp,
                              input logic [SIZE_BITS-1:0] w,
                              input logic [SIZE_BITS-1:0] h);
        cfg_write <= 1'b1;
        cfg_index <= REG_FRAME_INTERVAL;
        cfg_data  <= iv;
        @(posedge clk);
        cfg_index <= REG_KEYFRAME_SPACING;
        cfg_data  <= {16'($urandom), sp};
        @(posedge clk);
        cfg_index <= REG_EXPECTED_WIDTH;
        cfg_data  <= {10'($urandom), w};
        @(posedge clk);
        cfg_index <= REG_EXPECTED_HEIGHT;
        cfg_data  <= {10'($urandom), h};
        @(posedge clk);
        cfg_write    <= 1'b0;
        interval_cfg = iv;
        spacing_cfg  = sp;
        width_cfg    = w;
        height_cfg   = h;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    task automatic test_startup_pacing();
        logic [TIME_BITS-1:0] t;
        logic [TIME_BITS-1:0] jump_t;
        logic [TIME_BITS-1:0] step;
        step = TIME_BITS'(FRAME_INTERVAL_RESET);
        send_frame(random_rotation());
        t = 63'd5000;
        send_frame(make_frame(t, 1'b1, 1'b1));
        send_frame(make_frame(t + 63'd100, 1'b1, 1'b1));
        t = t + step;
        send_frame(make_frame(t, 1'b1, 1'b1));
        t = t + step;
        send_frame(make_frame(t, 1'b0, 1'b1));
        t = t + step;
        send_frame(make_frame(t, 1'b1, 1'b0));
        // far jump: due time catches up to one interval behind
        jump_t = t + step * 63'd20;
        send_frame(make_frame(jump_t, 1'b1, 1'b1));
        send_frame(random_rotation());
        // frame behind the new origin
        send_frame(make_frame(jump_t - 63'd80000, 1'b1, 1'b1));
        send_frame(make_frame(jump_t + step, 1'b1, 1'b0));
    endtask

    task automatic test_interval_extremes();
        wait_idle();
        set_config(24'd1, 8'd1, 14'd1, 14'd16383);
        repeat (4) send_frame(random_frame());
        wait_idle();
        set_config(24'd0, 8'd0, 14'd16383, 14'd1);
        repeat (4) send_frame(random_frame());
        wait_idle();
        set_config(24'd10000000, 8'd255, 14'd1920, 14'd1080);
        repeat (4) send_frame(random_frame());
    endtask

    task automatic run_pacing_phase(input logic [INTERVAL_BITS-1:0] iv,
                                    input logic [SPACING_BITS-1:0] sp,
                                    input logic [SIZE_BITS-1:0] w,
                                    input logic [SIZE_BITS-1:0] h,
                                    input logic [TIME_BITS-1:0] base,
                                    input bit tx_on, input bit rx_on, input int n);
        wait_idle();
        set_config(iv, sp, w, h);
        jump_base    = base;
        jump_pending = 1'b1;
        tx_idle_on   = tx_on;
        rx_idle_on   = rx_on;
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 6)
                send_frame(random_rotation());
            else
                send_frame(random_frame());
        end
    endtask

    task automatic test_random_pacing();
        run_pacing_phase(INTERVAL_BITS'($urandom_range(1, 10000000)),
                         SPACING_BITS'($urandom_range(1, 255)),
                         SIZE_BITS'($urandom_range(1, 16383)),
                         SIZE_BITS'($urandom_range(1, 16383)),
                         (63'd1 << 33) + TIME_BITS'($urandom), 1'b1, 1'b1, 240);
        run_pacing_phase(FRAME_INTERVAL_RESET, KEYFRAME_SPACING_RESET,
                         EXPECTED_WIDTH_RESET, EXPECTED_HEIGHT_RESET,
                         (63'd1 << 45) + TIME_BITS'($urandom), 1'b0, 1'b0, 240);
        run_pacing_phase(24'd10000000, 8'd255, SIZE_BITS'($urandom_range(1, 16383)),
                         SIZE_BITS'($urandom_range(1, 16383)),
                         (63'd1 << 52) + TIME_BITS'($urandom), 1'b1, 1'b0, 240);
        run_pacing_phase(24'd1, 8'd2, 14'd16383, 14'd16383,
                         (63'd1 << 58) + TIME_BITS'($urandom), 1'b0, 1'b1, 240);
        run_pacing_phase(24'd0, 8'd0, 14'd1, 14'd1, (63'd1 << 61) + TIME_BITS'($urandom),
                         1'b1, 1'b1, 240);
        // top of the time range: due time saturates
        run_pacing_phase(24'd10000000, 8'd3, SIZE_BITS'($urandom_range(1, 16383)),
                         SIZE_BITS'($urandom_range(1, 16383)), TIME_MAX - (63'd1 << 30),
                         1'b1, 1'b1, 240);
    endtask

    task automatic test_size_stop();
        item_t it;
        it = random_frame();
        it.frame_height = height_cfg ^ 14'($urandom_range(1, 16383));
        send_frame(it);
        send_frame(random_frame());
        send_frame(random_rotation());
        it = random_frame();
        it.frame_width = ~width_cfg;
        send_frame(it);
    endtask

    always @(posedge clk)
    begin
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            results_if.ready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 99) < 15) begin
            rx_stall_left = pick_gap() - 1;
            results_if.ready <= 1'b0;
        end
        else begin
            results_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && results_if.valid && results_if.ready) begin
            got = results_if.payload;
            if (outcome_q.size() == 0) begin
                report_mismatch("unexpected result, action", 64'(got.action), '0);
            end
            else begin
                want = outcome_q.pop_front();
                if (got.action != want.action)
                    report_mismatch("action", 64'(got.action), 64'(want.action));
                if (got.sample_time != want.sample_time)
                    report_mismatch("sample_time", 64'(got.sample_time),
                                    64'(want.sample_time));
                if (got.force_keyframe != want.force_keyframe)
                    report_mismatch("force_keyframe", 64'(got.force_keyframe),
                                    64'(want.force_keyframe));
                if (got.written_count != want.written_count)
                    report_mismatch("written_count", 64'(got.written_count),
                                    64'(want.written_count));
                if (got.dropped_count != want.dropped_count)
                    report_mismatch("dropped_count", 64'(got.dropped_count),
                                    64'(want.dropped_count));
                if (got.rejected_count != want.rejected_count)
                    report_mismatch("rejected_count", 64'(got.rejected_count),
                                    64'(want.rejected_count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("capture_frame_pacer_core: mismatch");
            $finish;
        end
    end

    initial begin
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        frames_if.valid   = 1'b0;
        frames_if.payload = '0;
        results_if.ready  = 1'b0;
        mismatch_count    = 0;
        cycle_count       = 0;
        rx_stall_left     = 0;
        tx_idle_on        = 1'b1;
        rx_idle_on        = 1'b1;
        jump_pending      = 1'b0;
        jump_base         = '0;
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_startup_pacing();
        test_interval_extremes();
        test_random_pacing();
        test_size_stop();
        wait_idle();
        if (mismatch_count == 0)
            $display("capture_frame_pacer_core: match");
        else
            $display("capture_frame_pacer_core: mismatch");
        $finish;
    end

endmodule
